// File: src/dpw_pkg.sv
// shared types and constants for the depth pixel to world point pipeline
package dpw_pkg;

	// image size
	localparam int IMAGE_WIDTH  = 640;
	localparam int IMAGE_HEIGHT = 480;

	// field widths
	localparam int COL_W   = 10;
	localparam int ROW_W   = 9;
	localparam int DEPTH_W = 16;
	localparam int CHAN_W  = 8;
	localparam int COORD_W = 32;
	localparam int QUAT_W  = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// camera point coordinate width, signed Q16
	localparam int CAM_W = 24;
	// rotation entry width, signed Q28
	localparam int ROT_W = 34;

	// twice the principal point
	localparam int CX_TWICE = 651;
	localparam int CY_TWICE = 507;

	// reduced divisors with their half (rounded down) for round to nearest
	localparam int DEN_X  = 32375;
	localparam int HALF_X = DEN_X / 2;
	localparam int DEN_Y  = 64875;
	localparam int HALF_Y = DEN_Y / 2;
	localparam int DEN_Z  = 125;
	localparam int OFS_Z  = 62;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_QUAT_W  = 3'd0,
		REG_QUAT_X  = 3'd1,
		REG_QUAT_Y  = 3'd2,
		REG_QUAT_Z  = 3'd3,
		REG_TRANS_X = 3'd4,
		REG_TRANS_Y = 3'd5,
		REG_TRANS_Z = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} color_t;

	typedef struct packed {
		logic signed [CAM_W-1:0] x;
		logic signed [CAM_W-1:0] y;
		logic signed [CAM_W-1:0] z;
		color_t                  color;
	} cam_t;

	// row major rotation matrix and translation
	typedef struct packed {
		logic [8:0][ROT_W-1:0]   r;
		logic [2:0][COORD_W-1:0] t;
	} pose_t;

endpackage

// File: src/dpw_pix_if.sv
// pixel request channel
interface dpw_pix_if;
	import dpw_pkg::*;

	logic               valid;
	logic               ready;
	logic [COL_W-1:0]   column;
	logic [ROW_W-1:0]   row;
	logic [DEPTH_W-1:0] depth_raw;
	logic [CHAN_W-1:0]  blue_in;
	logic [CHAN_W-1:0]  green_in;
	logic [CHAN_W-1:0]  red_in;

	modport source (
		output valid, column, row, depth_raw, blue_in, green_in, red_in,
		input  ready
	);
	modport sink (
		input  valid, column, row, depth_raw, blue_in, green_in, red_in,
		output ready
	);
endinterface

// File: src/dpw_pt_if.sv
// world point result channel
interface dpw_pt_if;
	import dpw_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] world_x;
	logic signed [COORD_W-1:0] world_y;
	logic signed [COORD_W-1:0] world_z;
	logic [CHAN_W-1:0]         blue_out;
	logic [CHAN_W-1:0]         green_out;
	logic [CHAN_W-1:0]         red_out;
	logic                      clipped;

	modport source (
		output valid, world_x, world_y, world_z, blue_out, green_out, red_out, clipped,
		input  ready
	);
	modport sink (
		input  valid, world_x, world_y, world_z, blue_out, green_out, red_out, clipped,
		output ready
	);
endinterface

// File: src/dpw_cfg_if.sv
// register write channel
interface dpw_cfg_if;
	import dpw_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

// File: src/dpw_pose.sv
// pose registers and rotation matrix built from the quaternion
module dpw_pose (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr,
	input  logic [dpw_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [dpw_pkg::CFG_DATA_W-1:0]  wr_data,
	output dpw_pkg::pose_t                  pose
);
	import dpw_pkg::*;

	localparam logic signed [ROT_W-1:0] ONE_Q28 = 34'sh1000_0000;

	logic signed [QUAT_W-1:0]  qw_q, qx_q, qy_q, qz_q;
	logic [COORD_W-1:0]        tx_q, ty_q, tz_q;
	logic signed [31:0]        xx_q, yy_q, zz_q, wx_q, wy_q, wz_q, xy_q, xz_q, yz_q;
	logic [8:0][ROT_W-1:0]     rot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qw_q <= 16'sd16384;
			qx_q <= '0;
			qy_q <= '0;
			qz_q <= '0;
			tx_q <= '0;
			ty_q <= '0;
			tz_q <= '0;
		end else if (wr) begin
			unique case (wr_index)
				REG_QUAT_W:  qw_q <= wr_data[QUAT_W-1:0];
				REG_QUAT_X:  qx_q <= wr_data[QUAT_W-1:0];
				REG_QUAT_Y:  qy_q <= wr_data[QUAT_W-1:0];
				REG_QUAT_Z:  qz_q <= wr_data[QUAT_W-1:0];
				REG_TRANS_X: tx_q <= wr_data[COORD_W-1:0];
				REG_TRANS_Y: ty_q <= wr_data[COORD_W-1:0];
				REG_TRANS_Z: tz_q <= wr_data[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	// quaternion products, recomputed every cycle
	always_ff @(posedge clk) begin
		xx_q <= 32'(qx_q) * 32'(qx_q);
		yy_q <= 32'(qy_q) * 32'(qy_q);
		zz_q <= 32'(qz_q) * 32'(qz_q);
		wx_q <= 32'(qw_q) * 32'(qx_q);
		wy_q <= 32'(qw_q) * 32'(qy_q);
		wz_q <= 32'(qw_q) * 32'(qz_q);
		xy_q <= 32'(qx_q) * 32'(qy_q);
		xz_q <= 32'(qx_q) * 32'(qz_q);
		yz_q <= 32'(qy_q) * 32'(qz_q);
	end

	always_ff @(posedge clk) begin
		rot_q[0] <= ONE_Q28 - ((34'(yy_q) + 34'(zz_q)) <<< 1);
		rot_q[1] <= (34'(xy_q) - 34'(wz_q)) <<< 1;
		rot_q[2] <= (34'(xz_q) + 34'(wy_q)) <<< 1;
		rot_q[3] <= (34'(xy_q) + 34'(wz_q)) <<< 1;
		rot_q[4] <= ONE_Q28 - ((34'(xx_q) + 34'(zz_q)) <<< 1);
		rot_q[5] <= (34'(yz_q) - 34'(wx_q)) <<< 1;
		rot_q[6] <= (34'(xz_q) - 34'(wy_q)) <<< 1;
		rot_q[7] <= (34'(yz_q) + 34'(wx_q)) <<< 1;
		rot_q[8] <= ONE_Q28 - ((34'(xx_q) + 34'(yy_q)) <<< 1);
	end

	assign pose.r = rot_q;
	assign pose.t = {tz_q, ty_q, tx_q};

endmodule

// File: src/dpw_lift.sv
// back-projection of a depth pixel to a camera point, six stages
module dpw_lift (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [dpw_pkg::COL_W-1:0]     column,
	input  logic [dpw_pkg::ROW_W-1:0]     row,
	input  logic [dpw_pkg::DEPTH_W-1:0]   depth_raw,
	input  dpw_pkg::color_t               color,
	output logic                          out_valid,
	input  logic                          out_ready,
	output dpw_pkg::cam_t                 cam
);
	import dpw_pkg::*;

	// reciprocals for the quotient estimate, exact up to one low
	localparam int SH_XY = 37;
	localparam int SH_Z  = 30;
	localparam logic [22:0] RECIP_X = 23'((64'd1 << SH_XY) / DEN_X);
	localparam logic [21:0] RECIP_Y = 22'((64'd1 << SH_XY) / DEN_Y);
	localparam logic [23:0] RECIP_Z = 24'((64'd1 << SH_Z) / DEN_Z);

	logic en1, en2, en3, en4, en5, en6;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic keep;
	logic [10:0] twice_u;
	logic [9:0]  twice_v;
	logic        negx, negy;
	logic [10:0] dx;
	logic [9:0]  dy;

	logic        negx_s1, negy_s1;
	logic [9:0]  magx_s1;
	logic [8:0]  magy_s1;
	logic [15:0] depth_s1;
	color_t      col_s1;

	logic        negx_s2, negy_s2;
	logic [25:0] ax_s2;
	logic [24:0] ay_s2;
	logic [29:0] nz_s2;
	color_t      col_s2;

	logic        negx_s3, negy_s3;
	logic [36:0] nx_s3, ny_s3;
	logic [29:0] nz_s3;
	color_t      col_s3;

	logic [59:0] px;
	logic [58:0] py;
	logic [53:0] pz;

	logic        negx_s4, negy_s4;
	logic [36:0] nx_s4, ny_s4;
	logic [29:0] nz_s4;
	logic [22:0] qx_s4;
	logic [21:0] qy_s4;
	logic [22:0] qz_s4;
	color_t      col_s4;

	logic [36:0] remx, remy;
	logic [29:0] remz;

	logic        negx_s5, negy_s5;
	logic [22:0] qx_s5;
	logic [21:0] qy_s5;
	logic [22:0] qz_s5;
	logic [15:0] rx_s5;
	logic [16:0] ry_s5;
	logic [7:0]  rz_s5;
	color_t      col_s5;

	logic [22:0] qx, qz;
	logic [21:0] qy;

	cam_t cam_s6;

	// a stage takes a new request when it is empty or its content moves on
	assign en6 = !v_s6 || out_ready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	// zero depth or a pixel off the image gives no point
	assign keep = (depth_raw != '0) && (13'(column) < 13'(IMAGE_WIDTH))
		&& (13'(row) < 13'(IMAGE_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid && keep;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// stage 1: offsets to the principal point as sign and magnitude
	always_comb begin
		twice_u = {column, 1'b0};
		twice_v = {row, 1'b0};
		negx = twice_u < 11'(CX_TWICE);
		negy = twice_v < 10'(CY_TWICE);
		dx = negx ? (11'(CX_TWICE) - twice_u) : (twice_u - 11'(CX_TWICE));
		dy = negy ? (10'(CY_TWICE) - twice_v) : (twice_v - 10'(CY_TWICE));
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			negx_s1  <= negx;
			negy_s1  <= negy;
			magx_s1  <= dx[9:0];
			magy_s1  <= dy[8:0];
			depth_s1 <= depth_raw;
			col_s1   <= color;
		end
	end

	// stage 2: offsets times depth, and the z numerator with its rounding half
	always_ff @(posedge clk) begin
		if (en2) begin
			negx_s2 <= negx_s1;
			negy_s2 <= negy_s1;
			ax_s2   <= 26'(magx_s1) * 26'(depth_s1);
			ay_s2   <= 25'(magy_s1) * 25'(depth_s1);
			nz_s2   <= 30'({depth_s1, 13'b0}) + 30'(OFS_Z);
			col_s2  <= col_s1;
		end
	end

	// stage 3: scaled numerators with the rounding half
	always_ff @(posedge clk) begin
		if (en3) begin
			negx_s3 <= negx_s2;
			negy_s3 <= negy_s2;
			nx_s3   <= 37'({ax_s2, 11'b0}) + 37'(HALF_X);
			ny_s3   <= 37'({ay_s2, 12'b0}) + 37'(HALF_Y);
			nz_s3   <= nz_s2;
			col_s3  <= col_s2;
		end
	end

	// stage 4: quotient estimate by reciprocal
	assign px = 60'(nx_s3) * 60'(RECIP_X);
	assign py = 59'(ny_s3) * 59'(RECIP_Y);
	assign pz = 54'(nz_s3) * 54'(RECIP_Z);

	always_ff @(posedge clk) begin
		if (en4) begin
			negx_s4 <= negx_s3;
			negy_s4 <= negy_s3;
			nx_s4   <= nx_s3;
			ny_s4   <= ny_s3;
			nz_s4   <= nz_s3;
			qx_s4   <= px[59:37];
			qy_s4   <= py[58:37];
			qz_s4   <= pz[52:30];
			col_s4  <= col_s3;
		end
	end

	// stage 5: remainder of the estimate, below twice the divisor
	assign remx = nx_s4 - 37'(qx_s4) * 37'(DEN_X);
	assign remy = ny_s4 - 37'(qy_s4) * 37'(DEN_Y);
	assign remz = nz_s4 - 30'(qz_s4) * 30'(DEN_Z);

	always_ff @(posedge clk) begin
		if (en5) begin
			negx_s5 <= negx_s4;
			negy_s5 <= negy_s4;
			qx_s5   <= qx_s4;
			qy_s5   <= qy_s4;
			qz_s5   <= qz_s4;
			rx_s5   <= remx[15:0];
			ry_s5   <= remy[16:0];
			rz_s5   <= remz[7:0];
			col_s5  <= col_s4;
		end
	end

	// stage 6: correct the quotient and restore the sign
	always_comb begin
		qx = qx_s5 + 23'(rx_s5 >= 16'(DEN_X));
		qy = qy_s5 + 22'(ry_s5 >= 17'(DEN_Y));
		qz = qz_s5 + 23'(rz_s5 >= 8'(DEN_Z));
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			cam_s6.x     <= negx_s5 ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
			cam_s6.y     <= negy_s5 ? -$signed({2'b0, qy}) : $signed({2'b0, qy});
			cam_s6.z     <= $signed({1'b0, qz});
			cam_s6.color <= col_s5;
		end
	end

	assign out_valid = v_s6;
	assign cam = cam_s6;

endmodule

// File: src/dpw_xform.sv
// rotation, rounding, translation and saturation of a camera point, four stages
module dpw_xform (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  dpw_pkg::cam_t                      cam,
	input  dpw_pkg::pose_t                     pose,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [dpw_pkg::COORD_W-1:0] world_x,
	output logic signed [dpw_pkg::COORD_W-1:0] world_y,
	output logic signed [dpw_pkg::COORD_W-1:0] world_z,
	output dpw_pkg::color_t                    color,
	output logic                               clipped
);
	import dpw_pkg::*;

	localparam int PROD_W = ROT_W + CAM_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam logic signed [SUM_W-1:0] HALF_Q28 = 60'sh000_0000_0800_0000;

	logic en7, en8, en9, en10;
	logic v_s7, v_s8, v_s9, v_s10;

	logic signed [CAM_W-1:0]  c [3];
	logic signed [PROD_W-1:0] prod_s7 [9];
	color_t                   col_s7;
	logic signed [SUM_W-1:0]  sum_s8 [3];
	color_t                   col_s8;
	logic signed [SUM_W-1:0]  biased [3];
	logic signed [COORD_W-1:0] rnd_s9 [3];
	color_t                   col_s9;
	logic signed [COORD_W:0]  full [3];
	logic signed [COORD_W-1:0] sat [3];
	logic [2:0]               over;
	logic signed [COORD_W-1:0] world_s10 [3];
	logic                     clip_s10;
	color_t                   col_s10;

	assign en10 = !v_s10 || out_ready;
	assign en9  = !v_s9 || en10;
	assign en8  = !v_s8 || en9;
	assign en7  = !v_s7 || en8;
	assign in_ready = en7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			if (en7)  v_s7  <= in_valid;
			if (en8)  v_s8  <= v_s7;
			if (en9)  v_s9  <= v_s8;
			if (en10) v_s10 <= v_s9;
		end
	end

	assign c[0] = cam.x;
	assign c[1] = cam.y;
	assign c[2] = cam.z;

	// stage 7: matrix entry times coordinate, Q44
	always_ff @(posedge clk) begin
		if (en7) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s7[3*i+j] <= PROD_W'($signed(pose.r[3*i+j])) * PROD_W'(c[j]);
				end
			end
			col_s7 <= cam.color;
		end
	end

	// stage 8: row sums
	always_ff @(posedge clk) begin
		if (en8) begin
			for (int i = 0; i < 3; i++) begin
				sum_s8[i] <= SUM_W'(prod_s7[3*i]) + SUM_W'(prod_s7[3*i+1])
					+ SUM_W'(prod_s7[3*i+2]);
			end
			col_s8 <= col_s7;
		end
	end

	// stage 9: to Q16, nearest with ties away from zero
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			biased[i] = sum_s8[i] + (sum_s8[i][SUM_W-1] ? (HALF_Q28 - 60'sd1) : HALF_Q28);
		end
	end

	always_ff @(posedge clk) begin
		if (en9) begin
			for (int i = 0; i < 3; i++) begin
				rnd_s9[i] <= biased[i][SUM_W-1:28];
			end
			col_s9 <= col_s8;
		end
	end

	// stage 10: translate and clamp
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			full[i] = (COORD_W+1)'(rnd_s9[i]) + (COORD_W+1)'($signed(pose.t[i]));
			over[i] = full[i][COORD_W] != full[i][COORD_W-1];
			if (over[i]) begin
				sat[i] = full[i][COORD_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			end else begin
				sat[i] = full[i][COORD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en10) begin
			for (int i = 0; i < 3; i++) begin
				world_s10[i] <= sat[i];
			end
			clip_s10 <= |over;
			col_s10  <= col_s9;
		end
	end

	assign out_valid = v_s10;
	assign world_x = world_s10[0];
	assign world_y = world_s10[1];
	assign world_z = world_s10[2];
	assign color   = col_s10;
	assign clipped = clip_s10;

endmodule

// File: src/depth_pixel_to_world_point.sv
// top level: depth pixel to world point, pinhole back-projection with pose
// pipeline from pixel request to result: six stages of camera lift
// (reciprocal divide with one correction step) and four of rotation and translation
// throughput one pixel per cycle while the result is taken; a request with zero depth or off the image gives nothing
// every stage moves on when empty or drained, so stalls only back up through full stages
// reset empties the pipeline and loads the identity pose with zero translation
module depth_pixel_to_world_point (
	input  logic      clk,
	input  logic      arst_n,
	dpw_pix_if.sink   pixel,
	dpw_pt_if.source  point,
	dpw_cfg_if.sink   cfg
);
	import dpw_pkg::*;

	pose_t  pose;
	cam_t   cam;
	logic   cam_valid;
	logic   cam_ready;
	color_t pix_color;
	color_t pt_color;

	assign cfg.ready = 1'b1;

	dpw_pose u_pose (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (cfg.valid && cfg.ready),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.pose     (pose)
	);

	assign pix_color.blue  = pixel.blue_in;
	assign pix_color.green = pixel.green_in;
	assign pix_color.red   = pixel.red_in;

	dpw_lift u_lift (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel.valid),
		.in_ready  (pixel.ready),
		.column    (pixel.column),
		.row       (pixel.row),
		.depth_raw (pixel.depth_raw),
		.color     (pix_color),
		.out_valid (cam_valid),
		.out_ready (cam_ready),
		.cam       (cam)
	);

	dpw_xform u_xform (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cam_valid),
		.in_ready  (cam_ready),
		.cam       (cam),
		.pose      (pose),
		.out_valid (point.valid),
		.out_ready (point.ready),
		.world_x   (point.world_x),
		.world_y   (point.world_y),
		.world_z   (point.world_z),
		.color     (pt_color),
		.clipped   (point.clipped)
	);

	assign point.blue_out  = pt_color.blue;
	assign point.green_out = pt_color.green;
	assign point.red_out   = pt_color.red;

	// with no result waiting the whole pipeline can move
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!point.valid |-> pixel.ready)
		else $error("pixel request refused with empty output");

	// a clipped point has a coordinate at a range limit
	a_clip_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		point.valid && point.clipped |->
			point.world_x == 32'sh7FFF_FFFF || point.world_x == 32'sh8000_0000 ||
			point.world_y == 32'sh7FFF_FFFF || point.world_y == 32'sh8000_0000 ||
			point.world_z == 32'sh7FFF_FFFF || point.world_z == 32'sh8000_0000)
		else $error("clipped set without a saturated coordinate");

	// a camera point stalled between the two halves is held
	a_cam_held: assert property (@(posedge clk) disable iff (!arst_n)
		cam_valid && !cam_ready |=> cam_valid && $stable(cam))
		else $error("camera point lost or changed while stalled");

endmodule
